// File: sv/wbps_pkg.sv
// Shared types, widths and constants of the wildcard byte pattern search unit.
package wbps_pkg;

   localparam int PATTERN_MAX_DEF = 128;
   localparam int BLOCK_BYTES_DEF = 524288;

   localparam int BYTE_W = 8;
   localparam int IDX_W  = 7;
   localparam int ADDR_W = 48;
   localparam int OFF_W  = 19;
   localparam int CNT_W  = 20;
   localparam int CSR_W  = 8;
   // wide enough for the register value and for any pattern depth up to 256
   localparam int LEN_CMP_W = 9;

   localparam int RSP_DEPTH = 3;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 2;

   localparam logic KIND_DATA    = 1'b0;
   localparam logic KIND_PATTERN = 1'b1;

   typedef struct packed {
      logic shift;   // window moves one place this cycle
      logic inject;  // this cell takes the incoming byte
      logic active;  // cell lies inside the pattern length
   } cell_ctl_type;

   typedef struct packed {
      logic                wild;
      logic [BYTE_W-1:0]   value;
   } pat_entry_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   match_address;
      logic [OFF_W-1:0]    match_offset;
   } rsp_entry_type;

endpackage

// File: sv/wbps_if.sv
// Valid/ready channel interfaces for request and response transfers.
interface wbps_req_if;
   logic                               valid;
   logic                               ready;
   logic                               kind;
   logic [wbps_pkg::BYTE_W-1:0]        data_byte;
   logic [wbps_pkg::IDX_W-1:0]         pattern_index;
   logic                               pattern_wild;
   logic [wbps_pkg::ADDR_W-1:0]        block_base;
   logic                               block_end;

   modport source (
      output valid, kind, data_byte, pattern_index, pattern_wild, block_base, block_end,
      input  ready
   );
   modport sink (
      input  valid, kind, data_byte, pattern_index, pattern_wild, block_base, block_end,
      output ready
   );
endinterface

interface wbps_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [wbps_pkg::ADDR_W-1:0]        match_address;
   logic [wbps_pkg::OFF_W-1:0]         match_offset;

   modport source (
      output valid, match_address, match_offset,
      input  ready
   );
   modport sink (
      input  valid, match_address, match_offset,
      output ready
   );
endinterface

// File: sv/wbps_cell.sv
// One match cell: a pattern entry and the window byte aligned against it.
module wbps_cell (
   input  logic                          clock,
   input  wbps_pkg::cell_ctl_type        ctl,
   input  logic [wbps_pkg::BYTE_W-1:0]   new_byte,
   input  logic [wbps_pkg::BYTE_W-1:0]   next_byte,
   input  logic                          pat_we,
   input  wbps_pkg::pat_entry_type       pat_entry,
   output logic [wbps_pkg::BYTE_W-1:0]   win_byte,
   output logic                          hit
);

   logic [wbps_pkg::BYTE_W-1:0]   win_ff;
   logic [wbps_pkg::BYTE_W-1:0]   win_in;
   wbps_pkg::pat_entry_type       pat_ff;

   // the cell at the pattern's end takes the new byte, the rest take their upper neighbour's
   assign win_in = ctl.inject ? new_byte : next_byte;

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         win_ff <= win_in;
      end
      if (pat_we) begin
         pat_ff <= pat_entry;
      end
   end

   assign win_byte = win_ff;
   assign hit      = !ctl.active || pat_ff.wild || (pat_ff.value == win_ff);

endmodule

// File: sv/wbps_window_mem.sv
// Circular history of recent data bytes, used to realign the cells.
module wbps_window_mem #(
   parameter int DEPTH = wbps_pkg::PATTERN_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          we,
   input  logic [$clog2(DEPTH)-1:0]      waddr,
   input  logic [wbps_pkg::BYTE_W-1:0]   wdata,
   input  logic [$clog2(DEPTH)-1:0]      raddr,
   output logic [wbps_pkg::BYTE_W-1:0]   rdata
);

   logic [wbps_pkg::BYTE_W-1:0] mem_ff [DEPTH];
   logic [wbps_pkg::BYTE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/wbps_rsp_fifo.sv
// Three-entry response queue between the match stage and the output channel.
module wbps_rsp_fifo (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  wbps_pkg::rsp_entry_type             push_data,
   input  logic                                pop,
   output logic                                not_empty,
   output wbps_pkg::rsp_entry_type             head,
   output logic [wbps_pkg::RSP_CNT_W-1:0]      occupancy
);

   wbps_pkg::rsp_entry_type                 buf_ff [wbps_pkg::RSP_DEPTH];
   logic [wbps_pkg::RSP_PTR_W-1:0]          wr_ff, wr_in;
   logic [wbps_pkg::RSP_PTR_W-1:0]          rd_ff, rd_in;
   logic [wbps_pkg::RSP_CNT_W-1:0]          cnt_ff, cnt_in;
   logic                                    do_pop;

   localparam logic [wbps_pkg::RSP_PTR_W-1:0] PtrLast =
      wbps_pkg::RSP_PTR_W'(wbps_pkg::RSP_DEPTH - 1);

   assign do_pop = pop && (cnt_ff != '0);

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PtrLast) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PtrLast) ? '0 : rd_ff + 1'b1;
      end
      if (push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ff] <= push_data;
      end
   end

   assign not_empty = (cnt_ff != '0);
   assign head      = buf_ff[rd_ff];
   assign occupancy = cnt_ff;

endmodule

// File: sv/wildcard_byte_pattern_search_unit.sv
// Top level of the wildcard byte pattern search unit.
//
//   channel    | dir | handshake     | payload
//   -----------+-----+---------------+------------------------------------------------
//   req_chan   | in  | valid / ready | kind, data_byte, pattern_index, pattern_wild,
//              |     |               | block_base, block_end
//   rsp_chan   | out | valid / ready | match_address, match_offset
//   csr_*      | in  | csr_we        | csr_wdata = pattern_length
//
// One request transfer per cycle. A data byte's match result passes the match
// stage register and is written into the response queue before it can leave;
// the three-entry queue keeps requests flowing while responses stall, and
// outside realignment req_chan.ready drops only once the queue could fill.
// Reset is synchronous and clears control state only. After each csr write the
// cells are realigned from the byte history; no request is taken until it ends.

module wildcard_byte_pattern_search_unit #(
   parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF,
   parameter int BLOCK_BYTES = wbps_pkg::BLOCK_BYTES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [wbps_pkg::CSR_W-1:0]   csr_wdata,
   wbps_req_if.sink                     req_chan,
   wbps_rsp_if.source                   rsp_chan
);

   localparam int PTR_W = $clog2(PATTERN_MAX);
   localparam int LEN_W = $clog2(PATTERN_MAX + 1);
   localparam int SUM_W = PTR_W + 1;

   localparam logic [PTR_W-1:0]              PtrLast = PTR_W'(PATTERN_MAX - 1);
   localparam logic [SUM_W-1:0]              PmaxSum = SUM_W'(PATTERN_MAX);
   localparam logic [wbps_pkg::LEN_CMP_W-1:0] PmaxCmp = wbps_pkg::LEN_CMP_W'(PATTERN_MAX);
   localparam logic [wbps_pkg::CNT_W:0]      BlockLim = (wbps_pkg::CNT_W + 1)'(BLOCK_BYTES);

   // realignment sequencer
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LOAD = 3'b010,
      ST_RUN  = 3'b100
   } state_type;

   state_type                        state_ff, state_in;
   logic [wbps_pkg::CSR_W-1:0]       csr_ff;
   logic [LEN_W-1:0]                 len_eff;
   logic [wbps_pkg::LEN_CMP_W-1:0]   len_cmp;

   logic [PTR_W-1:0]                 wptr_ff, wptr_in;
   logic [PTR_W-1:0]                 rd_ff, rd_in;
   logic [LEN_W-1:0]                 left_ff, left_in;
   logic                             rvalid_ff, rvalid_in;
   logic [SUM_W-1:0]                 wp_x, len_x, start_x;
   logic [wbps_pkg::BYTE_W-1:0]      hist_byte;

   logic [wbps_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [wbps_pkg::CNT_W-1:0]       cnt_new;
   logic                             block_close;

   // match stage, in the cycle after the byte transfer
   logic                             s1_valid_ff;
   logic                             s1_ge_ff;
   logic [wbps_pkg::CNT_W-1:0]       s1_off_ff;
   logic [wbps_pkg::ADDR_W-1:0]      s1_base_ff;

   logic                             req_xfer, data_xfer, pat_xfer;
   logic                             shift;
   logic [wbps_pkg::BYTE_W-1:0]      src_byte;
   wbps_pkg::pat_entry_type          pat_entry;

   wbps_pkg::cell_ctl_type           ctl [PATTERN_MAX];
   logic [wbps_pkg::BYTE_W-1:0]      win [PATTERN_MAX];
   logic [PATTERN_MAX-1:0]           hit;
   logic [PATTERN_MAX-1:0]           pat_we;

   logic                             push;
   wbps_pkg::rsp_entry_type          push_data;
   wbps_pkg::rsp_entry_type          head;
   logic                             rsp_not_empty;
   logic [wbps_pkg::RSP_CNT_W-1:0]   occ;
   logic [wbps_pkg::RSP_CNT_W:0]     inflight;

   // transfers
   assign req_xfer  = req_chan.valid && req_chan.ready;
   assign data_xfer = req_xfer && (req_chan.kind == wbps_pkg::KIND_DATA);
   assign pat_xfer  = req_xfer && (req_chan.kind == wbps_pkg::KIND_PATTERN);

   // results in flight must always find room in the queue
   assign inflight      = (wbps_pkg::RSP_CNT_W + 1)'(occ) + (wbps_pkg::RSP_CNT_W + 1)'(s1_valid_ff);
   assign req_chan.ready = (state_ff == ST_IDLE) &&
                           (inflight <= (wbps_pkg::RSP_CNT_W + 1)'(wbps_pkg::RSP_DEPTH - 1));

   // pattern length: zero acts as one, clamp at the cell count
   always_comb begin
      len_cmp = wbps_pkg::LEN_CMP_W'(csr_ff);
      if (len_cmp == '0) begin
         len_cmp = wbps_pkg::LEN_CMP_W'(1);
      end
      if (len_cmp > PmaxCmp) begin
         len_cmp = PmaxCmp;
      end
      len_eff = LEN_W'(len_cmp);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= wbps_pkg::CSR_W'(1);
      end else if (csr_we) begin
         csr_ff <= csr_wdata;
      end
   end

   // oldest byte of the new window: wptr - len, modulo the history depth
   assign wp_x    = SUM_W'(wptr_ff);
   assign len_x   = SUM_W'(len_eff);
   assign start_x = (wp_x >= len_x) ? wp_x - len_x : wp_x + PmaxSum - len_x;

   always_comb begin
      state_in  = state_ff;
      rd_in     = rd_ff;
      left_in   = left_ff;
      rvalid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_LOAD: begin
            rd_in    = start_x[PTR_W-1:0];
            left_in  = len_eff;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (left_ff != '0) begin
               rvalid_in = 1'b1;
               left_in   = left_ff - 1'b1;
               rd_in     = (rd_ff == PtrLast) ? '0 : rd_ff + 1'b1;
            end else if (!rvalid_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // a new length restarts the replay
      if (csr_we) begin
         state_in  = ST_LOAD;
         rvalid_in = 1'b0;
      end
   end

   // block byte count and history write pointer
   assign cnt_new     = count_ff + 1'b1;
   assign block_close = req_chan.block_end || ({1'b0, cnt_new} >= BlockLim);
   assign count_in    = block_close ? '0 : cnt_new;
   assign wptr_in     = (wptr_ff == PtrLast) ? '0 : wptr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rd_ff       <= '0;
         left_ff     <= '0;
         rvalid_ff   <= 1'b0;
         count_ff    <= '0;
         wptr_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_ff       <= rd_in;
         left_ff     <= left_in;
         rvalid_ff   <= rvalid_in;
         s1_valid_ff <= data_xfer;
         if (data_xfer) begin
            count_ff <= count_in;
            wptr_ff  <= wptr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (data_xfer) begin
         s1_ge_ff   <= (cnt_new >= wbps_pkg::CNT_W'(len_eff));
         s1_off_ff  <= cnt_new - wbps_pkg::CNT_W'(len_eff);
         s1_base_ff <= req_chan.block_base;
      end
   end

   wbps_window_mem #(
      .DEPTH (PATTERN_MAX)
   ) u_hist (
      .clock (clock),
      .we    (data_xfer),
      .waddr (wptr_ff),
      .wdata (req_chan.data_byte),
      .raddr (rd_ff),
      .rdata (hist_byte)
   );

   // cell chain: bytes enter at the cell of the last pattern entry and move down
   assign shift     = data_xfer || rvalid_ff;
   assign src_byte  = data_xfer ? req_chan.data_byte : hist_byte;
   assign pat_entry = '{wild: req_chan.pattern_wild, value: req_chan.data_byte};

   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      logic [wbps_pkg::BYTE_W-1:0] next_byte;

      if (k == PATTERN_MAX - 1) begin : g_top
         assign next_byte = src_byte;
      end else begin : g_mid
         assign next_byte = win[k+1];
      end

      assign ctl[k].shift  = shift;
      assign ctl[k].inject = (int'(len_eff) == k + 1);
      assign ctl[k].active = (k < int'(len_eff));
      // indexes beyond the cell count match no cell and are dropped
      assign pat_we[k]     = pat_xfer && (int'(req_chan.pattern_index) == k);

      wbps_cell u_cell (
         .clock     (clock),
         .ctl       (ctl[k]),
         .new_byte  (src_byte),
         .next_byte (next_byte),
         .pat_we    (pat_we[k]),
         .pat_entry (pat_entry),
         .win_byte  (win[k]),
         .hit       (hit[k])
      );
   end

   // match decision and result address
   assign push = s1_valid_ff && s1_ge_ff && (&hit);
   assign push_data.match_address = s1_base_ff + wbps_pkg::ADDR_W'(s1_off_ff);
   assign push_data.match_offset  = s1_off_ff[wbps_pkg::OFF_W-1:0];

   wbps_rsp_fifo u_rsp (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (rsp_chan.ready),
      .not_empty (rsp_not_empty),
      .head      (head),
      .occupancy (occ)
   );

   assign rsp_chan.valid         = rsp_not_empty;
   assign rsp_chan.match_address = head.match_address;
   assign rsp_chan.match_offset  = head.match_offset;

   // checks
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push |-> (occ != wbps_pkg::RSP_CNT_W'(wbps_pkg::RSP_DEPTH)) || rsp_chan.ready)
      else $error("response queue overflow");

   a_push_follows_byte : assert property (@(posedge clock) disable iff (reset)
      push |-> $past(data_xfer))
      else $error("result without a preceding data transfer");

   a_no_req_in_replay : assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_chan.ready)
      else $error("request taken while realigning");

   a_csr_starts_replay : assert property (@(posedge clock) disable iff (reset)
      csr_we |=> (state_ff == ST_LOAD))
      else $error("csr write did not start realignment");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the wildcard byte pattern search unit.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import wbps_pkg::*;

   localparam int PATTERN_MAX = PATTERN_MAX_DEF;
   localparam int BLOCK_BYTES = BLOCK_BYTES_DEF;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      logic                kind;
      logic [BYTE_W-1:0]   data_byte;
      logic [IDX_W-1:0]    pattern_index;
      logic                pattern_wild;
      logic [ADDR_W-1:0]   block_base;
      logic                block_end;
   } req_item_type;

   typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_mode_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_we;
   logic [CSR_W-1:0]  csr_wdata;

   wbps_req_if req_if ();
   wbps_rsp_if rsp_if ();

   wildcard_byte_pattern_search_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Search predictor: own copy of the pattern table, byte history, block
   // byte count and length register. Entry 0 of the history is the newest
   // byte; pattern entry 0 lines up with the oldest byte of the match.
   // ---------------------------------------------------------------------
   pat_entry_type              pat_table [PATTERN_MAX];
   logic [PATTERN_MAX*8-1:0]   recent = '0;
   logic [CNT_W-1:0]           byte_count = '0;
   logic [CSR_W-1:0]           csr_length = 8'd1;
   rsp_entry_type              pending_matches [$];

   // stimulus side: what the pattern table will hold once queued writes land
   pat_entry_type              plan_pat [PATTERN_MAX];
   bit                         plan_known [PATTERN_MAX];
   req_item_type               req_queue [$];
   logic [ADDR_W-1:0]          blk_base = '0;
   int                         end_odds = 30;

   int unsigned                fault_count = 0;
   bit                         calm = 1'b0;     // no idling in the closing part
   bit                         hold_arm = 1'b0;
   bit                         hold_done;
   int                         hold_left;

   function automatic int eff_len(input logic [CSR_W-1:0] v);
      // zero acts as one, anything past the table depth as the full depth
      if (v == 0)
         return 1;
      if (v > PATTERN_MAX)
         return PATTERN_MAX;
      return int'(v);
   endfunction

   task automatic scan_for_match(input req_item_type r);
      int            eff;
      int            k;
      bit            hit;
      logic [19:0]   off;
      rsp_entry_type m;
      if (r.kind == KIND_PATTERN) begin
         // pattern load: no result, window and block count untouched
         pat_table[r.pattern_index].wild  = r.pattern_wild;
         pat_table[r.pattern_index].value = r.data_byte;
         return;
      end
      recent = {recent[PATTERN_MAX*8-9:0], r.data_byte};
      byte_count = byte_count + 1'b1;
      eff = eff_len(csr_length);
      // a short block reports nothing until it holds a full pattern
      if (byte_count >= eff) begin
         hit = 1'b1;
         for (k = 0; k < eff && hit; k++)
            if (!pat_table[k].wild && pat_table[k].value != recent[8*(eff-1-k) +: 8])
               hit = 1'b0;
         if (hit) begin
            off = byte_count - 20'(eff);
            m.match_offset  = off[OFF_W-1:0];
            // base of the completing byte, wraps at 48 bits
            m.match_address = r.block_base + 48'(off);
            pending_matches = {pending_matches, m};
         end
      end
      // block closes on its end flag or once it reaches its maximum size
      if (r.block_end || byte_count >= BLOCK_BYTES)
         byte_count = '0;
   endtask

   function automatic bit gap_roll(input idle_mode_type mode);
      case (mode)
         IDLE_NONE:  return 1'b0;
         IDLE_LIGHT: return $urandom_range(0, 7) == 0;
         default:    return $urandom_range(0, 2) == 0;
      endcase
   endfunction

   task automatic log_fault(input string msg);
      fault_count++;
      if (fault_count <= 10)
         $display("%s", msg);
   endtask

   // ---------------------------------------------------------------------
   // Request driver: pops the pending queue, idles in bursts, predicts on
   // every accepted transfer.
   // ---------------------------------------------------------------------
   req_item_type  cur_req;
   int            tx_gap = 0;
   int unsigned   tx_tick = 0;
   idle_mode_type tx_mode = IDLE_NONE;

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         tx_gap       <= 0;
      end else begin
         if (req_if.valid && req_if.ready)
            scan_for_match(cur_req);
         tx_tick <= tx_tick + 1;
         if (tx_tick % 64 == 0)
            tx_mode <= idle_mode_type'($urandom_range(0, 2));
         // a new item only once the last one has gone or none was offered
         if (!req_if.valid || req_if.ready) begin
            if (tx_gap != 0) begin
               tx_gap       <= tx_gap - 1;
               req_if.valid <= 1'b0;
            end else if (!calm && gap_roll(tx_mode)) begin
               tx_gap       <= $urandom_range(0, 11);
               req_if.valid <= 1'b0;
            end else if (req_queue.size() != 0) begin
               cur_req = req_queue.pop_front();
               req_if.kind          <= cur_req.kind;
               req_if.data_byte     <= cur_req.data_byte;
               req_if.pattern_index <= cur_req.pattern_index;
               req_if.pattern_wild  <= cur_req.pattern_wild;
               req_if.block_base    <= cur_req.block_base;
               req_if.block_end     <= cur_req.block_end;
               req_if.valid         <= 1'b1;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off so that the response queue fills and the
   // request side has to stall
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_arm && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor: every transfer against the oldest expected match.
   // ---------------------------------------------------------------------
   rsp_entry_type oldest;
   int            rx_stall = 0;
   int unsigned   rx_tick = 0;
   idle_mode_type rx_mode = IDLE_NONE;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rx_stall     <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_matches.size() == 0) begin
               log_fault($sformatf("unexpected match: address %h offset %h",
                                   rsp_if.match_address, rsp_if.match_offset));
            end else begin
               oldest = pending_matches.pop_front();
               if (rsp_if.match_address !== oldest.match_address ||
                   rsp_if.match_offset !== oldest.match_offset)
                  log_fault($sformatf(
                     "match mismatch: address exp %h got %h, offset exp %h got %h",
                     oldest.match_address, rsp_if.match_address,
                     oldest.match_offset, rsp_if.match_offset));
            end
         end
         rx_tick <= rx_tick + 1;
         if (rx_tick % 64 == 0)
            rx_mode <= idle_mode_type'($urandom_range(0, 2));
         if (hold_left != 0) begin
            rsp_if.ready <= 1'b0;
         end else if (rx_stall != 0) begin
            rx_stall     <= rx_stall - 1;
            rsp_if.ready <= 1'b0;
         end else if (!calm && gap_roll(rx_mode)) begin
            rx_stall     <= $urandom_range(0, 11);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic logic [BYTE_W-1:0] pick_byte();
      // narrow alphabet most of the time so that partial matches are common
      case ($urandom_range(0, 9))
         0, 1:    return 8'h00;
         2, 3:    return 8'hFF;
         4:       return 8'hA5;
         5, 6:    return 8'h5A;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [ADDR_W-1:0] pick_base();
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0:       return 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 300));
         1:       return 48'(r[15:0]);
         default: return r[ADDR_W-1:0];
      endcase
   endfunction

   task automatic push_req(input logic kind, input logic [BYTE_W-1:0] b,
                           input logic [IDX_W-1:0] idx, input logic wild,
                           input logic [ADDR_W-1:0] base, input logic last);
      req_item_type it;
      it.kind          = kind;
      it.data_byte     = b;
      it.pattern_index = idx;
      it.pattern_wild  = wild;
      it.block_base    = base;
      it.block_end     = last;
      if (kind == KIND_PATTERN) begin
         plan_pat[idx].wild  = wild;
         plan_pat[idx].value = b;
         plan_known[idx]     = 1'b1;
      end
      req_queue = {req_queue, it};
   endtask

   // pattern load with the unused fields left random
   task automatic push_pattern(input int idx, input logic [BYTE_W-1:0] b, input logic wild);
      push_req(KIND_PATTERN, b, IDX_W'(idx), wild, pick_base(), 1'($urandom_range(0, 1)));
   endtask

   task automatic push_data(input logic [BYTE_W-1:0] b);
      logic last;
      if ($urandom_range(0, 49) == 0)
         blk_base = pick_base();          // base may move inside a block
      last = $urandom_range(0, end_odds - 1) == 0;
      push_req(KIND_DATA, b, IDX_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
               blk_base, last);
      if (last)
         blk_base = pick_base();
   endtask

   // wait until all transfers are done and every match has come back
   task automatic settle();
      do
         @(negedge clock);
      while (req_queue.size() != 0 || req_if.valid || pending_matches.size() != 0);
      repeat (10) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_length(input logic [CSR_W-1:0] v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      csr_length = v;
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // one setting of the length: load the table first, then stream bytes that
   // mix planted copies of the pattern with noise
   task automatic search_phase(input logic [CSR_W-1:0] len_value, input int n_bytes);
      int            eff;
      int            sent;
      int            k;
      int            pick;
      pat_entry_type e;
      eff = eff_len(len_value);
      for (k = 0; k < eff; k++)
         if (!plan_known[k] || $urandom_range(0, 3) == 0)
            push_pattern(k, pick_byte(), $urandom_range(0, 3) == 0);
      settle();
      write_length(len_value);
      end_odds = (eff <= 8) ? 30 : eff * 4;
      sent = 0;
      while (sent < n_bytes) begin
         pick = $urandom_range(0, 19);
         if (pick < 10) begin
            for (k = 0; k < eff; k++) begin
               e = plan_pat[k];
               push_data(e.wild ? pick_byte() : e.value);
            end
            sent += eff;
         end else if (pick < 12) begin
            // rewrite while streaming, anywhere in the table
            push_pattern($urandom_range(0, PATTERN_MAX - 1), pick_byte(),
                         $urandom_range(0, 3) == 0);
         end else begin
            push_data(pick_byte());
            sent++;
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int                k;
      logic [BYTE_W-1:0] b;
      req_if.valid         = 1'b0;
      req_if.kind          = KIND_DATA;
      req_if.data_byte     = '0;
      req_if.pattern_index = '0;
      req_if.pattern_wild  = 1'b0;
      req_if.block_base    = '0;
      req_if.block_end     = 1'b0;
      rsp_if.ready         = 1'b0;
      csr_we               = 1'b0;
      csr_wdata            = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: length one after reset, address wrap at the top of the map
      push_req(KIND_PATTERN, 8'hFF, 7'd0, 1'b0, 48'hFFFF_FFFF_FFFF, 1'b1);
      push_req(KIND_DATA, 8'hFF, 7'h7F, 1'b1, 48'hFFFF_FFFF_FFFF, 1'b0);
      push_req(KIND_DATA, 8'h00, 7'h7F, 1'b1, 48'hFFFF_FFFF_FFFF, 1'b0);
      push_req(KIND_DATA, 8'hFF, 7'h00, 1'b0, 48'hFFFF_FFFF_FFFF, 1'b0);
      push_req(KIND_DATA, 8'hFF, 7'h00, 1'b0, 48'hFFFF_FFFF_FFFF, 1'b1);
      push_req(KIND_DATA, 8'hFF, 7'h7F, 1'b1, 48'h0, 1'b0);
      // wildcard matches anything
      push_req(KIND_PATTERN, 8'h00, 7'd0, 1'b1, 48'h0, 1'b0);
      push_req(KIND_DATA, 8'h5A, 7'h00, 1'b0, 48'h0, 1'b0);
      push_req(KIND_DATA, 8'hA5, 7'h00, 1'b0, 48'h0, 1'b1);
      // last table slot, then a three-entry pattern FF 00 <any>
      push_req(KIND_PATTERN, 8'h00, 7'h7F, 1'b0, 48'h0, 1'b0);
      push_req(KIND_PATTERN, 8'h00, 7'd1, 1'b0, 48'h0, 1'b0);
      push_req(KIND_PATTERN, 8'h7E, 7'd2, 1'b1, 48'h0, 1'b0);
      push_req(KIND_PATTERN, 8'hFF, 7'd0, 1'b0, 48'h0, 1'b0);
      settle();
      // length zero behaves as one
      write_length(8'd0);
      push_req(KIND_DATA, 8'hFF, 7'h00, 1'b0, 48'h0000_0000_1000, 1'b0);
      push_req(KIND_DATA, 8'h00, 7'h00, 1'b0, 48'h0000_0000_1000, 1'b1);
      settle();
      // short blocks never report, then matches inside one block
      write_length(8'd3);
      push_req(KIND_DATA, 8'hFF, 7'h00, 1'b0, 48'h0000_1234_5678, 1'b1);
      push_req(KIND_DATA, 8'hFF, 7'h00, 1'b0, 48'h0000_1234_5678, 1'b0);
      push_req(KIND_DATA, 8'h00, 7'h00, 1'b0, 48'h0000_1234_5678, 1'b1);
      push_req(KIND_DATA, 8'hFF, 7'h00, 1'b0, 48'h0000_1234_5678, 1'b0);
      push_req(KIND_DATA, 8'h00, 7'h00, 1'b0, 48'h0000_1234_5678, 1'b0);
      push_req(KIND_DATA, 8'h7E, 7'h00, 1'b0, 48'h0000_1234_5678, 1'b0);
      push_req(KIND_DATA, 8'h00, 7'h00, 1'b0, 48'h0000_1234_5678, 1'b0);
      push_req(KIND_DATA, 8'hFF, 7'h00, 1'b0, 48'h0000_1234_5678, 1'b0);
      push_req(KIND_DATA, 8'h00, 7'h00, 1'b0, 48'h0000_1234_5678, 1'b0);
      push_req(KIND_DATA, 8'h11, 7'h00, 1'b0, 48'h0000_1234_5678, 1'b1);

      // random phases across several lengths, extremes included
      blk_base = pick_base();
      search_phase(8'd2, 40);
      search_phase(8'd0, 30);
      search_phase(8'd6, 40);
      search_phase(8'($urandom_range(1, 16)), 40);

      // every byte matches while the receiver holds off: the block backs up
      push_pattern(0, 8'h00, 1'b1);
      settle();
      write_length(8'd1);
      end_odds = 30;
      hold_arm = 1'b1;
      for (k = 0; k < 40; k++)
         push_data(pick_byte());

      search_phase(8'd128, 40);
      search_phase(8'($urandom_range(4, 24)), 40);
      search_phase(8'd255, 40);
      search_phase(8'd1, 30);

      // closing part, no idling: back-to-back bytes against a one-byte
      // pattern, with a block end in the middle and matches scattered through
      calm = 1'b1;
      push_pattern(0, 8'h3C, 1'b0);
      settle();
      write_length(8'd1);
      blk_base = pick_base();
      for (k = 1; k <= 40; k++) begin
         b = 8'($urandom_range(0, 255));
         if (k == 1 || k == 20 || k == 21 || $urandom_range(0, 3) == 0)
            b = 8'h3C;
         push_req(KIND_DATA, b, IDX_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                  blk_base, k == 20 || k == 40);
      end
      settle();
      repeat (20) @(posedge clock);

      if (fault_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("testbench: errors");
      $finish;
   end

endmodule
